/* hw/rtl/smap_pkg.sv */
// ----------------------------------------------------------------------------
// Signed max-magnitude pooling: shared package
// Constants, register codes, entry and position types and the register
// saturation helpers used by the pooling block.
// ----------------------------------------------------------------------------
package smap_pkg;

  // Sizes of the stream fields and of the block-row store.
  localparam int SampleBits = 16;
  localparam int IndexBits  = 16;
  localparam int MaxRows    = 1024;
  localparam int AddrBits   = $clog2(MaxRows);
  localparam int MaxPool    = 256;
  localparam int DimBits    = 11;
  localparam int PoolBits   = 9;
  localparam int InBlkBits  = 8;
  localparam int CntBits    = 10;
  localparam int CfgIdxBits = 3;
  localparam int CfgBits    = 11;

  // Configuration register indexes.
  typedef enum logic [CfgIdxBits-1:0] {
    CfgImageRows  = 3'd0,
    CfgImageCols  = 3'd1,
    CfgPoolRows   = 3'd2,
    CfgPoolCols   = 3'd3,
    CfgSelectMode = 3'd4
  } cfg_reg_e;

  // One entry of the block-row store.
  typedef struct packed {
    logic signed [SampleBits-1:0] max_val;
    logic signed [SampleBits-1:0] min_val;
    logic [IndexBits-1:0]         max_off;
    logic [IndexBits-1:0]         min_off;
  } entry_t;

  localparam int EntryBits = $bits(entry_t);

  // Position of one pixel inside the image and its pooling block.
  typedef struct packed {
    logic                 start;
    logic                 emit;
    logic                 eoi;
    logic [IndexBits-1:0] off;
    logic [AddrBits-1:0]  brow;
  } pos_t;

  // Clamp an image dimension to 1..MaxRows.
  function automatic logic [DimBits-1:0] sat_dim(logic [DimBits-1:0] v);
    logic [DimBits-1:0] r;
    r = v;
    if (v == '0) begin
      r = DimBits'(1);
    end else if (v > DimBits'(MaxRows)) begin
      r = DimBits'(MaxRows);
    end
    return r;
  endfunction

  // Clamp a pool dimension to 1..MaxPool.
  function automatic logic [PoolBits-1:0] sat_pool(logic [PoolBits-1:0] v);
    logic [PoolBits-1:0] r;
    r = v;
    if (v == '0) begin
      r = PoolBits'(1);
    end else if (v > PoolBits'(MaxPool)) begin
      r = PoolBits'(MaxPool);
    end
    return r;
  endfunction

endpackage

/* hw/rtl/smap_if.sv */
// ----------------------------------------------------------------------------
// Signed max-magnitude pooling: stream interfaces
// Valid/ready channels for the pixel stream and the pooled result stream.
// ----------------------------------------------------------------------------

// Pixel stream.
interface smap_in_if;
  logic                                     valid;
  logic                                     ready;
  logic signed [smap_pkg::SampleBits-1:0]   sample;
  logic [smap_pkg::IndexBits-1:0]           given_index;

  modport source (output valid, output sample, output given_index, input ready);
  modport sink   (input valid, input sample, input given_index, output ready);
endinterface

// Pooled result stream.
interface smap_out_if;
  logic                                     valid;
  logic                                     ready;
  logic signed [smap_pkg::SampleBits-1:0]   pooled_value;
  logic [smap_pkg::IndexBits-1:0]           pooled_index;
  logic                                     end_of_image;

  modport source (output valid, output pooled_value, output pooled_index,
                  output end_of_image, input ready);
  modport sink   (input valid, input pooled_value, input pooled_index,
                  input end_of_image, output ready);
endinterface

/* hw/rtl/signed_max_abs_pool_2d_top.sv */
// ----------------------------------------------------------------------------
// Signed max-magnitude 2-D pooling, top level
// Streams pixels column-major, keeps per block row the running positive
// maximum and negative minimum in a RAM, and emits one result per block.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Payload                                     Handshake
//  in_i     sink       sample, given_index                         valid/ready
//  out_o    source     pooled_value, pooled_index, end_of_image    valid/ready
//  cfg      write      cfg_we_i, cfg_idx_i, cfg_data_i             none
//
//  One pixel per cycle sustained unless the output stalls; the last pixel of a
//  block is registered in the update stage, then its result in the output register.
//  The rate is set by the single read-modify-write of the block-row RAM,
//  with the last written entry forwarded to a following pixel of the same row.
//  After reset a clearing pass writes all 1024 entries, one per cycle; no
//  pixel is taken during the pass.
//  A stalled output register holds the update stage, which holds the input.
//
module signed_max_abs_pool_2d_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  smap_in_if.sink                           in_i,
  smap_out_if.source                        out_o,
  input  logic                              cfg_we_i,
  input  logic [smap_pkg::CfgIdxBits-1:0]   cfg_idx_i,
  input  logic [smap_pkg::CfgBits-1:0]      cfg_data_i
);

  // Configuration registers, held in saturated form.
  logic [smap_pkg::DimBits-1:0]  image_rows_q, image_cols_q;
  logic [smap_pkg::PoolBits-1:0] pool_rows_q, pool_cols_q;
  logic                          select_mode_q;

  // Clearing pass.
  logic                          clearing_q, clearing_d;
  logic [smap_pkg::AddrBits-1:0] clr_cnt_q, clr_cnt_d;

  // Update stage.
  logic                                   s1_valid_q, s1_valid_d;
  smap_pkg::pos_t                         s1_pos_q;
  logic signed [smap_pkg::SampleBits-1:0] s1_sample_q;
  logic [smap_pkg::IndexBits-1:0]         s1_given_q;
  logic                                   s1_sel_q;
  logic                                   s1_fire;

  // Forwarding of the last written entry.
  logic                          fwd_valid_q;
  logic [smap_pkg::AddrBits-1:0] fwd_addr_q;
  smap_pkg::entry_t              fwd_data_q;

  // Output register.
  logic                                   out_valid_q, out_valid_d;
  logic signed [smap_pkg::SampleBits-1:0] out_value_q;
  logic [smap_pkg::IndexBits-1:0]         out_index_q;
  logic                                   out_eoi_q;

  logic                                   in_xfer;
  smap_pkg::pos_t                         pos;
  smap_pkg::entry_t                       rd_entry, base, upd;
  logic [smap_pkg::EntryBits-1:0]         ram_rdata, ram_wdata;
  logic                                   ram_we;
  logic [smap_pkg::AddrBits-1:0]          ram_waddr;
  logic signed [smap_pkg::SampleBits:0]   max_ext, neg_min;
  logic                                   take_min;
  logic signed [smap_pkg::SampleBits-1:0] res_value;
  logic [smap_pkg::IndexBits-1:0]         res_index;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_rows_q  <= smap_pkg::DimBits'(1);
      image_cols_q  <= smap_pkg::DimBits'(1);
      pool_rows_q   <= smap_pkg::PoolBits'(2);
      pool_cols_q   <= smap_pkg::PoolBits'(2);
      select_mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        smap_pkg::CfgImageRows:  image_rows_q  <= smap_pkg::sat_dim(cfg_data_i);
        smap_pkg::CfgImageCols:  image_cols_q  <= smap_pkg::sat_dim(cfg_data_i);
        smap_pkg::CfgPoolRows:
          pool_rows_q <= smap_pkg::sat_pool(cfg_data_i[smap_pkg::PoolBits-1:0]);
        smap_pkg::CfgPoolCols:
          pool_cols_q <= smap_pkg::sat_pool(cfg_data_i[smap_pkg::PoolBits-1:0]);
        smap_pkg::CfgSelectMode: select_mode_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Handshakes: the update stage retires unless its result finds the output full.
  assign s1_fire   = s1_valid_q && (!s1_pos_q.emit || !out_valid_q || out_o.ready);
  assign in_i.ready = !clearing_q && (!s1_valid_q || s1_fire);
  assign in_xfer   = in_i.valid && in_i.ready;

  // Position of the incoming pixel.
  smap_pos u_pos (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .advance_i    (in_xfer),
    .image_rows_i (image_rows_q),
    .image_cols_i (image_cols_q),
    .pool_rows_i  (pool_rows_q),
    .pool_cols_i  (pool_cols_q),
    .pos_o        (pos)
  );

  // Block-row store: read on transfer, written back from the update stage.
  smap_ram #(
    .Width (smap_pkg::EntryBits),
    .Depth (smap_pkg::MaxRows)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (in_xfer),
    .raddr_i (pos.brow),
    .rdata_o (ram_rdata)
  );

  assign rd_entry  = smap_pkg::entry_t'(ram_rdata);
  assign ram_we    = clearing_q || s1_fire;
  assign ram_waddr = clearing_q ? clr_cnt_q : s1_pos_q.brow;
  assign ram_wdata = clearing_q ? '0 : upd;

  // Clearing pass after reset.
  always_comb begin
    clearing_d = clearing_q;
    clr_cnt_d  = clr_cnt_q;
    if (clearing_q) begin
      clr_cnt_d = clr_cnt_q + 1'b1;
      if (clr_cnt_q == smap_pkg::AddrBits'(smap_pkg::MaxRows - 1)) begin
        clearing_d = 1'b0;
      end
    end
  end

  // Entry before this pixel: cleared at block start, else forwarded or read.
  always_comb begin
    if (s1_pos_q.start) begin
      base         = '0;
      base.min_off = s1_sel_q ? s1_given_q : '0;
    end else if (fwd_valid_q && (fwd_addr_q == s1_pos_q.brow)) begin
      base = fwd_data_q;
    end else begin
      base = rd_entry;
    end
  end

  // Entry update for this pixel.
  always_comb begin
    upd = base;
    if (s1_sel_q) begin
      if (s1_pos_q.off == base.min_off) begin
        upd.min_val = s1_sample_q;
      end
    end else if (s1_sample_q > base.max_val) begin
      upd.max_val = s1_sample_q;
      upd.max_off = s1_pos_q.off;
    end else if (s1_sample_q < base.min_val) begin
      upd.min_val = s1_sample_q;
      upd.min_off = s1_pos_q.off;
    end
  end

  // Result choice: min in select mode, else negative side only if |min| > |max|.
  always_comb begin
    max_ext   = {upd.max_val[smap_pkg::SampleBits-1], upd.max_val};
    neg_min   = -$signed({upd.min_val[smap_pkg::SampleBits-1], upd.min_val});
    take_min  = s1_sel_q || (max_ext < neg_min);
    res_value = take_min ? upd.min_val : upd.max_val;
    res_index = take_min ? upd.min_off : upd.max_off;
  end

  // Output register and update stage valid next state.
  always_comb begin
    if (s1_fire && s1_pos_q.emit) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
    s1_valid_d = in_xfer ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_q);
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q  <= 1'b1;
      clr_cnt_q   <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      fwd_valid_q <= 1'b0;
    end else begin
      clearing_q  <= clearing_d;
      clr_cnt_q   <= clr_cnt_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (s1_fire) begin
        fwd_valid_q <= 1'b1;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_pos_q    <= pos;
      s1_sample_q <= in_i.sample;
      s1_given_q  <= in_i.given_index;
      s1_sel_q    <= select_mode_q;
    end
    if (s1_fire) begin
      fwd_addr_q <= s1_pos_q.brow;
      fwd_data_q <= upd;
    end
    if (s1_fire && s1_pos_q.emit) begin
      out_value_q <= res_value;
      out_index_q <= res_index;
      out_eoi_q   <= s1_pos_q.eoi;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.pooled_value = out_value_q;
  assign out_o.pooled_index = out_index_q;
  assign out_o.end_of_image = out_eoi_q;

  // A held update stage must block the input.
  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_fire) |-> !in_xfer)
    else $error("pixel taken while the update stage was held");

  // No pixel is in flight while the store is being cleared.
  a_no_item_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing_q |-> (!s1_valid_q && !out_valid_q))
    else $error("pixel in flight during the clearing pass");

  // A pending result is never replaced before its transfer.
  a_result_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_o.ready) |-> !(s1_fire && s1_pos_q.emit))
    else $error("pending result overwritten");

endmodule

/* hw/rtl/smap_ram.sv */
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module smap_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write and registered read; a read of the entry being written returns old data.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/smap_pos.sv */
// ----------------------------------------------------------------------------
// Signed max-magnitude pooling: position tracker
// Row, column and in-block counters; gives the block row, in-block offset and
// the block start, block end and image end flags of the pixel being accepted.
// ----------------------------------------------------------------------------
module smap_pos (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            advance_i,
  input  logic [smap_pkg::DimBits-1:0]    image_rows_i,
  input  logic [smap_pkg::DimBits-1:0]    image_cols_i,
  input  logic [smap_pkg::PoolBits-1:0]   pool_rows_i,
  input  logic [smap_pkg::PoolBits-1:0]   pool_cols_i,
  output smap_pkg::pos_t                  pos_o
);

  logic [smap_pkg::CntBits-1:0]   row_cnt_q, row_cnt_d;
  logic [smap_pkg::CntBits-1:0]   col_cnt_q, col_cnt_d;
  logic [smap_pkg::InBlkBits-1:0] rib_q, rib_d;
  logic [smap_pkg::InBlkBits-1:0] cib_q, cib_d;
  logic [smap_pkg::AddrBits-1:0]  brow_q, brow_d;

  logic                           last_row, last_col;
  logic                           rib_end, cib_end;
  logic [smap_pkg::IndexBits:0]   prod;

  // Limits of the current pixel; counters past a new limit count as at it.
  always_comb begin
    last_row = (smap_pkg::DimBits'(row_cnt_q) + smap_pkg::DimBits'(1)) >= image_rows_i;
    last_col = (smap_pkg::DimBits'(col_cnt_q) + smap_pkg::DimBits'(1)) >= image_cols_i;
    rib_end  = (smap_pkg::PoolBits'(rib_q) + smap_pkg::PoolBits'(1)) >= pool_rows_i;
    cib_end  = (smap_pkg::PoolBits'(cib_q) + smap_pkg::PoolBits'(1)) >= pool_cols_i;
    prod     = (smap_pkg::IndexBits'(cib_q) * smap_pkg::IndexBits'(pool_rows_i))
             + (smap_pkg::IndexBits+1)'(rib_q);
  end

  // Position of the pixel on the input.
  always_comb begin
    pos_o.start = (rib_q == '0) && (cib_q == '0);
    pos_o.emit  = (rib_end || last_row) && (cib_end || last_col);
    pos_o.eoi   = last_row && last_col;
    pos_o.off   = prod[smap_pkg::IndexBits-1:0];
    pos_o.brow  = brow_q;
  end

  // Counter stepping, row index fastest.
  always_comb begin
    row_cnt_d = row_cnt_q;
    col_cnt_d = col_cnt_q;
    rib_d     = rib_q;
    cib_d     = cib_q;
    brow_d    = brow_q;
    if (advance_i) begin
      if (last_row) begin
        row_cnt_d = '0;
        rib_d     = '0;
        brow_d    = '0;
        if (last_col) begin
          col_cnt_d = '0;
          cib_d     = '0;
        end else begin
          col_cnt_d = col_cnt_q + 1'b1;
          cib_d     = cib_end ? '0 : cib_q + 1'b1;
        end
      end else begin
        row_cnt_d = row_cnt_q + 1'b1;
        if (rib_end) begin
          rib_d  = '0;
          brow_d = brow_q + 1'b1;
        end else begin
          rib_d = rib_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_cnt_q <= '0;
      col_cnt_q <= '0;
      rib_q     <= '0;
      cib_q     <= '0;
      brow_q    <= '0;
    end else begin
      row_cnt_q <= row_cnt_d;
      col_cnt_q <= col_cnt_d;
      rib_q     <= rib_d;
      cib_q     <= cib_d;
      brow_q    <= brow_d;
    end
  end

endmodule

/* bench/signed_max_abs_pool_2d_top_tb.sv */
// ----------------------------------------------------------------------------
// Signed max-magnitude 2-D pooling: self-checking testbench
// Streams pixel images through the pooling block under a range of image and
// pool sizes in both the pooling and the index-select mode. A behavioural
// model of the block predicts every pooled result as each pixel is taken, and
// a monitor compares the results field by field in order. Both channels idle
// and stall at random.
// ----------------------------------------------------------------------------
module signed_max_abs_pool_2d_top_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DrainCycles = 8;
  localparam int MaxShown    = 10;
  localparam int RandPixels  = 675;

  typedef struct {
    logic signed [smap_pkg::SampleBits-1:0] sample;
    logic [smap_pkg::IndexBits-1:0]         given;
  } pixel_t;

  typedef struct packed {
    logic signed [smap_pkg::SampleBits-1:0] value;
    logic [smap_pkg::IndexBits-1:0]         index;
    logic                                   eoi;
  } pooled_t;

  logic                            clk_i;
  logic                            rst_ni;
  logic                            cfg_we;
  logic [smap_pkg::CfgIdxBits-1:0] cfg_idx;
  logic [smap_pkg::CfgBits-1:0]    cfg_data;

  smap_in_if  pix_if ();
  smap_out_if res_if ();

  signed_max_abs_pool_2d_top i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (pix_if),
    .out_o      (res_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  // Stimulus and expectation stores.
  pixel_t  pixel_q[$];
  pooled_t pooled_q[$];
  pixel_t  next_pixel;
  pooled_t want;

  // Register copies, raw as written.
  logic [10:0] img_rows_r, img_cols_r;
  logic [8:0]  pool_rows_r, pool_cols_r;
  logic        select_r;

  // Model state of the block-row store and the stream position.
  logic signed [smap_pkg::SampleBits-1:0] blk_max[smap_pkg::MaxRows];
  logic signed [smap_pkg::SampleBits-1:0] blk_min[smap_pkg::MaxRows];
  logic [smap_pkg::IndexBits-1:0]         blk_max_off[smap_pkg::MaxRows];
  logic [smap_pkg::IndexBits-1:0]         blk_min_off[smap_pkg::MaxRows];
  int unsigned row_cnt, col_cnt, row_in, col_in, brow_cnt;

  int unsigned gap_left, stall_left;
  bit          steady;
  int unsigned mismatches, pixels_taken, results_seen, settings_used;

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Watchdog.
  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
    if (v == 0) return 1;
    return (v > hi) ? hi : v;
  endfunction

  // Idle length: mostly none or short, now and then long.
  function automatic int unsigned draw_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (steady) return 0;
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  task automatic note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MaxShown) begin
      $display("MISMATCH: %s", msg);
    end
  endtask

  // Advance the model by one pixel and queue the pooled result it finishes.
  function automatic void pool_pixel(input logic signed [smap_pkg::SampleBits-1:0] s,
                                     input logic [smap_pkg::IndexBits-1:0] given);
    int unsigned ir, ic, pr, pc, b;
    logic [smap_pkg::IndexBits-1:0] off;
    bit last_row, last_col, row_end, col_end;
    pooled_t res;
    ir = clamp_dim(img_rows_r, smap_pkg::MaxRows);
    ic = clamp_dim(img_cols_r, 1024);
    pr = clamp_dim(pool_rows_r, smap_pkg::MaxPool);
    pc = clamp_dim(pool_cols_r, smap_pkg::MaxPool);
    b = brow_cnt % smap_pkg::MaxRows;
    off = smap_pkg::IndexBits'((col_in * pr + row_in) % 65536);
    last_row = (row_cnt + 1 >= ir);
    last_col = (col_cnt + 1 >= ic);
    row_end = (row_in + 1 >= pr) || last_row;
    col_end = (col_in + 1 >= pc) || last_col;

    // First pixel of a block clears its block-row entry.
    if (row_in == 0 && col_in == 0) begin
      blk_max[b]     = '0;
      blk_min[b]     = '0;
      blk_max_off[b] = '0;
      blk_min_off[b] = select_r ? given : '0;
    end

    if (select_r) begin
      if (off == blk_min_off[b]) blk_min[b] = s;
    end else if (s > blk_max[b]) begin
      blk_max[b]     = s;
      blk_max_off[b] = off;
    end else if (s < blk_min[b]) begin
      blk_min[b]     = s;
      blk_min_off[b] = off;
    end

    // The last pixel of a block yields its result; ties favour the positive.
    if (row_end && col_end) begin
      if (select_r || (int'(blk_max[b]) < -int'(blk_min[b]))) begin
        res.value = blk_min[b];
        res.index = blk_min_off[b];
      end else begin
        res.value = blk_max[b];
        res.index = blk_max_off[b];
      end
      res.eoi = last_row && last_col;
      pooled_q.push_back(res);
    end

    if (last_row) begin
      row_cnt  = 0;
      row_in   = 0;
      brow_cnt = 0;
      if (last_col) begin
        col_cnt = 0;
        col_in  = 0;
      end else begin
        col_cnt++;
        col_in = (col_in + 1 >= pc) ? 0 : col_in + 1;
      end
    end else begin
      row_cnt++;
      if (row_in + 1 >= pr) begin
        row_in = 0;
        brow_cnt++;
      end else begin
        row_in++;
      end
    end
  endfunction

  // Pixel driver: predicts on each transfer, then offers the next pixel.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      pix_if.valid <= 1'b0;
    end else begin
      if (pix_if.valid && pix_if.ready) begin
        pool_pixel(pix_if.sample, pix_if.given_index);
        pixels_taken++;
      end
      if (!pix_if.valid || pix_if.ready) begin
        if (gap_left != 0) begin
          pix_if.valid <= 1'b0;
          gap_left--;
        end else if (pixel_q.size() != 0) begin
          next_pixel = pixel_q.pop_front();
          pix_if.valid       <= 1'b1;
          pix_if.sample      <= next_pixel.sample;
          pix_if.given_index <= next_pixel.given;
          gap_left = draw_gap();
        end else begin
          pix_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor with random back-pressure.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        results_seen++;
        if (pooled_q.size() == 0) begin
          note_mismatch($sformatf("result with none expected: value %0d index %0d eoi %0b",
                                  res_if.pooled_value, res_if.pooled_index,
                                  res_if.end_of_image));
        end else begin
          want = pooled_q.pop_front();
          if (res_if.pooled_value !== want.value || res_if.pooled_index !== want.index ||
              res_if.end_of_image !== want.eoi) begin
            note_mismatch($sformatf(
                "result %0d: expected value %0d index %0d eoi %0b, got %0d %0d %0b",
                results_seen, want.value, want.index, want.eoi, res_if.pooled_value,
                res_if.pooled_index, res_if.end_of_image));
          end
        end
      end
      if (stall_left != 0) begin
        res_if.ready <= 1'b0;
        stall_left--;
      end else begin
        res_if.ready <= 1'b1;
        stall_left = draw_gap();
      end
    end
  end

  task automatic queue_pixel(input logic signed [smap_pkg::SampleBits-1:0] s,
                             input logic [smap_pkg::IndexBits-1:0] g);
    pixel_t p;
    p.sample = s;
    p.given  = g;
    pixel_q.push_back(p);
  endtask

  // Wait until every pixel is taken and every result has arrived, then let
  // the pipeline settle for pixels that finish no block.
  task automatic wait_drained();
    do @(negedge clk_i);
    while (pixel_q.size() != 0 || pix_if.valid || pooled_q.size() != 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input smap_pkg::cfg_reg_e idx, input logic [10:0] val);
    @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    case (idx)
      smap_pkg::CfgImageRows:  img_rows_r  = val;
      smap_pkg::CfgImageCols:  img_cols_r  = val;
      smap_pkg::CfgPoolRows:   pool_rows_r = val[8:0];
      smap_pkg::CfgPoolCols:   pool_cols_r = val[8:0];
      smap_pkg::CfgSelectMode: select_r    = val[0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic apply_setting(input logic [10:0] rows, input logic [10:0] cols,
                               input logic [10:0] prows, input logic [10:0] pcols,
                               input logic mode);
    wait_drained();
    write_reg(smap_pkg::CfgImageRows, rows);
    write_reg(smap_pkg::CfgImageCols, cols);
    write_reg(smap_pkg::CfgPoolRows, prows);
    write_reg(smap_pkg::CfgPoolCols, pcols);
    write_reg(smap_pkg::CfgSelectMode, {10'd0, mode});
    settings_used++;
  endtask

  // Sample mix: extremes, small values for ties, and full-range noise.
  function automatic logic signed [smap_pkg::SampleBits-1:0] draw_sample();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) begin
      case ($urandom_range(0, 4))
        0: return 16'sh7FFF;
        1: return 16'sh8000;
        2: return 16'sh0000;
        3: return -16'sd1;
        default: return 16'sd1;
      endcase
    end
    if (r < 4) return smap_pkg::SampleBits'(int'($urandom_range(0, 16)) - 8);
    return smap_pkg::SampleBits'($urandom);
  endfunction

  // Main sequence.
  initial begin
    int unsigned rand_pixels, phase, kind, n, ir, ic, pr, pc, block_px;
    logic [10:0] rows, cols, prows, pcols;
    logic        mode;
    logic [smap_pkg::IndexBits-1:0] g;

    rst_ni             = 1'b0;
    cfg_we             = 1'b0;
    cfg_idx            = '0;
    cfg_data           = '0;
    pix_if.valid       = 1'b0;
    pix_if.sample      = '0;
    pix_if.given_index = '0;
    res_if.ready       = 1'b0;
    img_rows_r  = 11'd1;
    img_cols_r  = 11'd1;
    pool_rows_r = 9'd2;
    pool_cols_r = 9'd2;
    select_r    = 1'b0;
    for (int i = 0; i < smap_pkg::MaxRows; i++) begin
      blk_max[i]     = '0;
      blk_min[i]     = '0;
      blk_max_off[i] = '0;
      blk_min_off[i] = '0;
    end
    row_cnt = 0; col_cnt = 0; row_in = 0; col_in = 0; brow_cnt = 0;
    gap_left = 0; stall_left = 0; steady = 1'b0;
    mismatches = 0; pixels_taken = 0; results_seen = 0; settings_used = 0;
    rand_pixels = 0;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset settings: every pixel is a whole 1x1 image.
    queue_pixel(16'sh7FFF, 16'hFFFF);
    queue_pixel(16'sh8000, 16'h0000);
    queue_pixel(16'sh0000, 16'hA5A5);

    // Pooling on a 3x3 image with edge blocks: largest negative beats the
    // largest positive, a tie, an all-zero block and a lone negative.
    apply_setting(11'd3, 11'd3, 11'd2, 11'd2, 1'b0);
    queue_pixel(16'sh7FFF, 16'hFFFF);
    queue_pixel(16'sh8000, 16'h0000);
    queue_pixel(16'sd5, 16'hFFFF);
    queue_pixel(-16'sd1, 16'h0000);
    queue_pixel(16'sd100, 16'hFFFF);
    queue_pixel(-16'sd5, 16'h0000);
    queue_pixel(16'sd0, 16'hFFFF);
    queue_pixel(16'sd0, 16'h0000);
    queue_pixel(-16'sd7, 16'hFFFF);

    // Select mode: a hit, an offset outside an edge block, and the top index.
    apply_setting(11'd3, 11'd3, 11'd2, 11'd2, 1'b1);
    queue_pixel(draw_sample(), 16'd3);
    queue_pixel(draw_sample(), 16'hFFFF);
    queue_pixel(draw_sample(), 16'd1);
    queue_pixel(draw_sample(), 16'h0000);
    queue_pixel(16'sh1234, 16'hFFFF);
    queue_pixel(draw_sample(), 16'd2);
    queue_pixel(draw_sample(), 16'd1);
    queue_pixel(16'sh8000, 16'h5555);
    queue_pixel(draw_sample(), 16'hFFFF);

    // Mode change half-way through a block.
    apply_setting(11'd2, 11'd2, 11'd2, 11'd2, 1'b0);
    queue_pixel(-16'sd300, 16'd0);
    queue_pixel(16'sd200, 16'd0);
    wait_drained();
    write_reg(smap_pkg::CfgSelectMode, 11'd1);
    queue_pixel(16'sd7, 16'd2);
    queue_pixel(-16'sd9, 16'd3);

    // Random settings; small images are sent as whole images, others in part,
    // so a later smaller setting also lands on counters past its limits.
    phase = 0;
    while (rand_pixels < RandPixels) begin
      kind = (phase < 2) ? phase : $urandom_range(0, 29);
      mode = 1'($urandom_range(0, 1));
      if (kind == 0) begin
        // Tall single column at the row limit.
        rows  = $urandom_range(0, 1) ? 11'd2047 : 11'd1024;
        cols  = $urandom_range(0, 1) ? 11'd0 : 11'd1;
        prows = $urandom_range(0, 2) == 0 ? 11'd511 : 11'($urandom_range(1, 3));
        pcols = $urandom_range(0, 1) ? 11'd256 : 11'd1;
        n = 150;
      end else if (kind == 1) begin
        // Wide single row at the column limit with the widest blocks.
        rows  = $urandom_range(0, 1) ? 11'd0 : 11'd1;
        cols  = $urandom_range(0, 1) ? 11'd2047 : 11'd1024;
        prows = $urandom_range(0, 1) ? 11'd256 : 11'd1;
        pcols = $urandom_range(0, 1) ? 11'd511 : 11'd256;
        n = 150;
      end else begin
        rows = ($urandom_range(0, 19) == 0) ? 11'd0 : 11'($urandom_range(1, 12));
        cols = ($urandom_range(0, 19) == 0) ? 11'd0 : 11'($urandom_range(1, 12));
        case ($urandom_range(0, 19))
          0:       prows = 11'd0;
          1:       prows = 11'($urandom_range(257, 511));
          2:       prows = 11'd256;
          default: prows = 11'($urandom_range(1, 5));
        endcase
        case ($urandom_range(0, 19))
          0:       pcols = 11'd0;
          1:       pcols = 11'($urandom_range(257, 511));
          2:       pcols = 11'd256;
          default: pcols = 11'($urandom_range(1, 5));
        endcase
        n = 0;
      end
      apply_setting(rows, cols, prows, pcols, mode);
      steady = ($urandom_range(0, 4) == 0);

      ir = clamp_dim(img_rows_r, smap_pkg::MaxRows);
      ic = clamp_dim(img_cols_r, 1024);
      pr = clamp_dim(pool_rows_r, smap_pkg::MaxPool);
      pc = clamp_dim(pool_cols_r, smap_pkg::MaxPool);
      block_px = pr * pc;
      if (n == 0) begin
        if ($urandom_range(0, 4) == 0) n = $urandom_range(1, 2 * ir * ic + 5);
        else n = ir * ic * ((60 / (ir * ic)) + 1);
      end
      // The last setting sends only what is left of the pixel budget.
      if (n > RandPixels - rand_pixels) n = RandPixels - rand_pixels;

      for (int k = 0; k < n; k++) begin
        if (mode && $urandom_range(0, 7) != 0) begin
          g = smap_pkg::IndexBits'($urandom_range(0, block_px - 1));
        end else begin
          g = smap_pkg::IndexBits'($urandom);
        end
        queue_pixel(draw_sample(), g);
      end
      rand_pixels += n;
      phase++;
    end

    wait_drained();
    steady = 1'b0;

    $display("Run covered %0d pixel transfers and %0d pooled results over %0d settings,",
             pixels_taken, results_seen, settings_used);
    $display("in pooling and select modes, with edge blocks and out-of-range registers.");
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches in total.", mismatches);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
hw/rtl/smap_pkg.sv
hw/rtl/smap_if.sv
hw/rtl/smap_ram.sv
hw/rtl/smap_pos.sv
hw/rtl/signed_max_abs_pool_2d_top.sv
bench/signed_max_abs_pool_2d_top_tb.sv
